[hw/rtl/assert_macros.svh]
// assertion macros shared by the stereo gain slew rtl
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define SGLS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define SGLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SGLS_ASSERT(lbl, ante, cons, msg)
`define SGLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/sgls_pkg.sv]
// shared widths, constants, item types and control structs
// for the stereo gain slew block; no dependencies
package sgls_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int ACC_EXTRA  = 16;
  localparam int ACC_W      = GAIN_W + ACC_EXTRA;
  localparam int STEP_W     = ACC_W + 1;
  localparam int COUNT_W    = 20;
  localparam int BLOCKS_W   = 8;
  localparam int FRAMES_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_CNT_W  = $clog2(ACC_W + 1);

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [ACC_W-1:0]   ACC_ONE   = ACC_W'(1) << (GAIN_FRAC + ACC_EXTRA);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_BLOCKS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_LENGTH  = CFG_IDX_W'(3);

  typedef struct packed {
    logic                       first_of_block;
    logic [GAIN_W-1:0]          target_gain;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       right_present;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_start;
    logic take_step;
    logic step;
    logic mul;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pending;
    logic div_done;
  } sts_t;

endpackage

[hw/rtl/stereo_gain_linear_slew_top.sv]
// stereo gain with linear slew: one stereo item in, one scaled item out
// sequence: accept, evaluate, step, multiply, output register; a new ramp adds the bit-serial step divide
// a new item is accepted only once the previous result is loaded into the output register
// reset: rst_n synchronous active low; gain 1.0, no ramp, config at documented defaults
// depends on sgls_pkg, sgls_ctrl, sgls_dp (with sgls_div)
module stereo_gain_linear_slew_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input item channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sgls_pkg::in_item_t                 in_item,
  // result item channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output sgls_pkg::out_item_t                out_item,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [sgls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // command and status between sequencer and datapath
  sgls_pkg::cmd_t cmd;
  sgls_pkg::sts_t sts;

  // sequencer: idle -> evaluate block start -> (divide) -> step gain -> multiply -> output
  // the output register holds a result while the next item is already accepted
  sgls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // datapath: ramp state, step divider, two 24x18 multipliers, round and saturate
  sgls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item),
    .out_item_o (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

[hw/rtl/sgls_div.sv]
// restoring divider for the ramp step, one quotient bit per cycle
// signed dividend, unsigned nonzero divisor, truncates toward zero; uses sgls_pkg
module sgls_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic [sgls_pkg::STEP_W-1:0]         dividend_i,
  input  logic [sgls_pkg::COUNT_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic [sgls_pkg::STEP_W-1:0]         quotient_o
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [sgls_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            neg_r;
  logic [sgls_pkg::ACC_W-1:0]      quo_r;
  logic [sgls_pkg::COUNT_W-1:0]    rem_r;

  logic [sgls_pkg::STEP_W-1:0]     dvd_abs;
  logic [sgls_pkg::COUNT_W:0]      rem_sh;
  logic [sgls_pkg::COUNT_W:0]      trial;
  logic                            ge;
  logic [sgls_pkg::STEP_W-1:0]     q_ext;

  assign dvd_abs = dividend_i[sgls_pkg::STEP_W-1] ? (sgls_pkg::STEP_W'(0) - dividend_i)
                                                  : dividend_i;
  assign rem_sh  = {rem_r, quo_r[sgls_pkg::ACC_W-1]};
  assign trial   = rem_sh - {1'b0, divisor_i};
  assign ge      = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = sgls_pkg::DIV_CNT_W'(sgls_pkg::ACC_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - sgls_pkg::DIV_CNT_W'(1);
      if (cnt_r == sgls_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      neg_r <= dividend_i[sgls_pkg::STEP_W-1];
      quo_r <= dvd_abs[sgls_pkg::ACC_W-1:0];
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[sgls_pkg::ACC_W-2:0], ge};
      rem_r <= ge ? trial[sgls_pkg::COUNT_W-1:0] : rem_sh[sgls_pkg::COUNT_W-1:0];
    end
  end

  assign q_ext      = {1'b0, quo_r};
  assign quotient_o = neg_r ? (sgls_pkg::STEP_W'(0) - q_ext) : q_ext;
  assign done_o     = done_r;

endmodule

[hw/rtl/sgls_ctrl.sv]
// sequencing state machine for the stereo gain slew block
// drives datapath commands and both handshakes; uses sgls_pkg and assert_macros.svh
`include "assert_macros.svh"

module sgls_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output sgls_pkg::cmd_t   cmd_o,
  input  sgls_pkg::sts_t   sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DLOAD = 3'd2;
  localparam logic [2:0] S_DWAIT = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_nxt  = sts_i.pending ? S_DLOAD : S_STEP;
      end
      S_DLOAD: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.take_step = 1'b1;
          state_nxt       = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd_o.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `SGLS_ASSERT(a_no_overwrite, out_valid_r && out_stall, !cmd_o.out_load, "held item overwritten")
  `SGLS_ASSERT_NEXT(a_accept_eval, in_valid && !in_stall, state_r == S_EVAL, "accept not evaluated")
  `SGLS_ASSERT(a_done_in_wait, sts_i.div_done, state_r == S_DWAIT, "divider done outside wait")

endmodule

[hw/rtl/sgls_dp.sv]
// datapath: config registers, gain ramp state, step divider, multipliers, rounding
// uses sgls_pkg, sgls_div and assert_macros.svh
`include "assert_macros.svh"

module sgls_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sgls_pkg::cmd_t                     cmd_i,
  output sgls_pkg::sts_t                     sts_o,
  input  sgls_pkg::in_item_t                 in_item_i,
  output sgls_pkg::out_item_t                out_item_o,
  input  logic                               cfg_wr_en,
  input  logic [sgls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W  = sgls_pkg::BLOCKS_W + sgls_pkg::FRAMES_W;
  localparam int SUM_W  = sgls_pkg::STEP_W + 1;
  localparam int PROD_W = sgls_pkg::SAMPLE_W + sgls_pkg::GAIN_W + 1;
  localparam int RES_W  = PROD_W - sgls_pkg::GAIN_FRAC;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (sgls_pkg::GAIN_FRAC - 1);
  localparam logic signed [RES_W-1:0]  RES_MAX  = RES_W'((2 ** (sgls_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [RES_W-1:0]  RES_MIN  = RES_W'(-(2 ** (sgls_pkg::SAMPLE_W - 1)));

  // round half up, then saturate to the sample range
  function automatic logic [sgls_pkg::SAMPLE_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] biased;
    logic signed [RES_W-1:0]  r;
    biased = p + RND_HALF;
    r      = RES_W'(biased >>> sgls_pkg::GAIN_FRAC);
    if (r > RES_MAX) begin
      return RES_MAX[sgls_pkg::SAMPLE_W-1:0];
    end else if (r < RES_MIN) begin
      return RES_MIN[sgls_pkg::SAMPLE_W-1:0];
    end
    return r[sgls_pkg::SAMPLE_W-1:0];
  endfunction

  // configuration
  logic                              slew_mode_r;
  logic [sgls_pkg::BLOCKS_W-1:0]     slew_blocks_r;
  logic [sgls_pkg::FRAMES_W-1:0]     block_frames_r;
  logic [sgls_pkg::COUNT_W-1:0]      ramp_length_r;

  // accepted item
  logic                              first_r;
  logic [sgls_pkg::GAIN_W-1:0]       tgt_in_r;
  logic signed [sgls_pkg::SAMPLE_W-1:0] left_r;
  logic signed [sgls_pkg::SAMPLE_W-1:0] right_r;

  // ramp state
  logic [sgls_pkg::ACC_W-1:0]        gain_now_r, gain_now_nxt;
  logic [sgls_pkg::GAIN_W-1:0]       target_r, target_nxt;
  logic [sgls_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [sgls_pkg::COUNT_W-1:0]      count_r, count_nxt;
  logic [sgls_pkg::COUNT_W-1:0]      total_r, total_nxt;
  logic                              running_r, running_nxt;
  logic [sgls_pkg::STEP_W-1:0]       diff_r;

  logic signed [PROD_W-1:0]          prod_l_r, prod_r_r;
  sgls_pkg::out_item_t               out_item_r;

  logic [sgls_pkg::GAIN_W-1:0]       tsat;
  logic [sgls_pkg::ACC_W-1:0]        t_acc;
  logic [sgls_pkg::ACC_W-1:0]        tgt_acc;
  logic                              changed, eq, pending;
  logic [sgls_pkg::BLOCKS_W-1:0]     blocks_eff;
  logic [LEN_W-1:0]                  blk_len, raw_len;
  logic [sgls_pkg::COUNT_W-1:0]      ramp_len;
  logic [sgls_pkg::STEP_W-1:0]       diff_nxt;
  logic [SUM_W-1:0]                  gain_sum;
  logic [sgls_pkg::ACC_W-1:0]        gain_clamp;
  logic                              last;
  logic [sgls_pkg::STEP_W-1:0]       div_quo;
  logic                              div_done;
  logic [sgls_pkg::GAIN_W-1:0]       gain_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slew_mode_r    <= 1'b0;
      slew_blocks_r  <= sgls_pkg::BLOCKS_W'(1);
      block_frames_r <= sgls_pkg::FRAMES_W'(256);
      ramp_length_r  <= sgls_pkg::COUNT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sgls_pkg::CFG_SLEW_MODE:    slew_mode_r    <= cfg_data[0];
        sgls_pkg::CFG_SLEW_BLOCKS:  slew_blocks_r  <= cfg_data[sgls_pkg::BLOCKS_W-1:0];
        sgls_pkg::CFG_BLOCK_FRAMES: block_frames_r <= cfg_data[sgls_pkg::FRAMES_W-1:0];
        sgls_pkg::CFG_RAMP_LENGTH:  ramp_length_r  <= cfg_data[sgls_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      first_r  <= in_item_i.first_of_block;
      tgt_in_r <= in_item_i.target_gain;
      left_r   <= in_item_i.left_in;
      right_r  <= in_item_i.right_present ? in_item_i.right_in : in_item_i.left_in;
    end
  end

  // block start evaluation
  assign tsat    = (tgt_in_r > sgls_pkg::GAIN_ONE) ? sgls_pkg::GAIN_ONE : tgt_in_r;
  assign t_acc   = {tsat, {sgls_pkg::ACC_EXTRA{1'b0}}};
  assign tgt_acc = {target_r, {sgls_pkg::ACC_EXTRA{1'b0}}};
  assign changed = (tsat != target_r);
  assign eq      = (gain_now_r == t_acc);
  assign pending = first_r & changed & ~eq;

  assign blocks_eff = (slew_blocks_r == '0) ? sgls_pkg::BLOCKS_W'(1) : slew_blocks_r;
  assign blk_len    = LEN_W'(blocks_eff) * LEN_W'(block_frames_r);
  assign raw_len    = slew_mode_r ? LEN_W'(ramp_length_r) : blk_len;
  assign ramp_len   = (raw_len == '0) ? sgls_pkg::COUNT_W'(1) :
                      (raw_len > LEN_W'(sgls_pkg::COUNT_MAX)) ? sgls_pkg::COUNT_MAX :
                      raw_len[sgls_pkg::COUNT_W-1:0];
  assign diff_nxt   = {1'b0, t_acc} - {1'b0, gain_now_r};

  // one ramp step, clamped to [0, 1.0]
  assign gain_sum = {2'b00, gain_now_r} + {step_r[sgls_pkg::STEP_W-1], step_r};
  always_comb begin
    if (gain_sum[SUM_W-1]) begin
      gain_clamp = '0;
    end else if (gain_sum > {2'b00, sgls_pkg::ACC_ONE}) begin
      gain_clamp = sgls_pkg::ACC_ONE;
    end else begin
      gain_clamp = gain_sum[sgls_pkg::ACC_W-1:0];
    end
  end
  assign last = ((sgls_pkg::COUNT_W + 1)'(count_r) + (sgls_pkg::COUNT_W + 1)'(1))
                >= (sgls_pkg::COUNT_W + 1)'(total_r);

  always_comb begin
    gain_now_nxt = gain_now_r;
    target_nxt   = target_r;
    step_nxt     = step_r;
    count_nxt    = count_r;
    total_nxt    = total_r;
    running_nxt  = running_r;
    if (cmd_i.eval && first_r) begin
      target_nxt  = tsat;
      running_nxt = ~eq;
      if (changed) begin
        count_nxt = '0;
        total_nxt = pending ? ramp_len : '0;
      end
    end
    if (cmd_i.take_step) begin
      step_nxt = div_quo;
    end
    if (cmd_i.step && running_r) begin
      if (last) begin
        gain_now_nxt = tgt_acc;
        count_nxt    = total_r;
        running_nxt  = 1'b0;
        step_nxt     = '0;
      end else begin
        gain_now_nxt = gain_clamp;
        count_nxt    = count_r + sgls_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_now_r <= sgls_pkg::ACC_ONE;
      target_r   <= sgls_pkg::GAIN_ONE;
      step_r     <= '0;
      count_r    <= '0;
      total_r    <= '0;
      running_r  <= 1'b0;
    end else begin
      gain_now_r <= gain_now_nxt;
      target_r   <= target_nxt;
      step_r     <= step_nxt;
      count_r    <= count_nxt;
      total_r    <= total_nxt;
      running_r  <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.eval) begin
      diff_r <= diff_nxt;
    end
  end

  sgls_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff_r),
    .divisor_i  (total_r),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // gain truncated to Q16 for the multiply
  assign gain_mul = gain_now_r[sgls_pkg::ACC_W-1:sgls_pkg::ACC_EXTRA];

  always_ff @(posedge clk) begin
    if (cmd_i.mul) begin
      prod_l_r <= $signed(left_r) * $signed({1'b0, gain_mul});
      prod_r_r <= $signed(right_r) * $signed({1'b0, gain_mul});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_item_r.left_out  <= round_sat(prod_l_r);
      out_item_r.right_out <= round_sat(prod_r_r);
    end
  end

  assign out_item_o     = out_item_r;
  assign sts_o.pending  = pending;
  assign sts_o.div_done = div_done;

  `SGLS_ASSERT(a_idle_at_target, !running_r, gain_now_r == tgt_acc, "idle gain off target")
  `SGLS_ASSERT(a_count_in_ramp, running_r, count_r < total_r, "ramp count past length")
  `SGLS_ASSERT_NEXT(a_gain_bounded, cmd_i.step, gain_now_r <= sgls_pkg::ACC_ONE, "gain above unity")

endmodule
